// ----- hdl/telnet_receive_negotiator_macros.svh -----
// Assertion macros used by the telnet receive negotiator checker.
`ifndef TELNET_RECEIVE_NEGOTIATOR_MACROS_SVH
`define TELNET_RECEIVE_NEGOTIATOR_MACROS_SVH

// Clocked assertion, off while reset is active.
`define TNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define TNR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/tnr_pkg.sv -----
// Types, byte codes and constants of the telnet receive negotiator.
package tnr_pkg;

  localparam int unsigned ECHO_BIT = 3;
  localparam int unsigned RAW_BIT  = 5;
  localparam logic [15:0] ECHO_MASK = 16'(1 << ECHO_BIT);
  localparam logic [15:0] RAW_MASK  = 16'(1 << RAW_BIT);

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] INTR_RST  = 8'd127;
  localparam logic [7:0] ERASE_RST = 8'd35;
  localparam logic [7:0] KILL_RST  = 8'd64;
  localparam logic [15:0] TTY_RST  = 16'd24;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_EL   = 8'd248;
  localparam logic [7:0] B_EC   = 8'd247;
  localparam logic [7:0] B_AYT  = 8'd246;
  localparam logic [7:0] B_IP   = 8'd244;
  localparam logic [7:0] B_BRK  = 8'd243;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_NUL  = 8'd0;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_BEL  = 8'd7;
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;

  typedef enum logic [5:0] {
    PH_DATA  = 6'b000001,
    PH_CR    = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_OPT   = 6'b001000,
    PH_SB    = 6'b010000,
    PH_SBIAC = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_e;

  typedef enum logic [1:0] {
    REG_INTR  = 2'd0,
    REG_ERASE = 2'd1,
    REG_KILL  = 2'd2,
    REG_TTY   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       discard_data;
  } in_word_t;

  typedef struct packed {
    logic       out_dest;
    logic [7:0] out_byte;
    logic [15:0] mode_flags;
    logic       last;
  } out_word_t;

  typedef struct packed {
    phase_e      phase;
    verb_e       verb;
    logic        echo_answered;
    logic        login_echo;
    logic        binary_in;
    logic        binary_out;
    logic [15:0] tty_flags;
    logic [15:0] saved_flags;
  } st_t;

  typedef struct packed {
    logic [7:0] intr_char;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0]      dests;
    logic [2:0][7:0] bytes;
    logic [15:0]     flags;
  } grp_t;

endpackage

// ----- hdl/tnr_decode.sv -----
// Per-byte parser: next parse state and the group of result words for one byte.
module tnr_decode (
  input  tnr_pkg::st_t     st_i,
  input  tnr_pkg::in_word_t word_i,
  input  tnr_pkg::cfg_t    cfg_i,
  output tnr_pkg::st_t     st_o,
  output tnr_pkg::grp_t    grp_o
);
  import tnr_pkg::*;

  st_t        n;
  grp_t       g;
  logic [7:0] c;
  logic [7:0] reply;
  logic       data_go;
  logic       neg_go;
  logic       silent;
  logic       enter;
  logic       leave;

  assign c = word_i.rx_byte;

  always_comb begin
    n       = st_i;
    g       = '0;
    data_go = 1'b0;
    neg_go  = 1'b0;
    silent  = 1'b0;
    enter   = 1'b0;
    leave   = 1'b0;
    reply   = B_WONT;

    unique case (st_i.phase)
      PH_CR: begin
        if (c == B_NUL || c == B_LF) begin
          n.phase = PH_DATA;
        end else if (c == B_IAC) begin
          n.phase = PH_CMD;
        end else begin
          data_go = 1'b1;
        end
      end
      PH_CMD: begin
        n.phase = PH_DATA;
        case (c) inside
          B_BRK, B_IP: begin
            g.cnt      = 2'd1;
            g.bytes[0] = (|(st_i.tty_flags & RAW_MASK)) ? B_NUL : cfg_i.intr_char;
          end
          B_AYT: begin
            g.cnt      = 2'd1;
            g.dests[0] = 1'b1;
            g.bytes[0] = B_BEL;
          end
          B_EC: begin
            g.cnt      = 2'd1;
            g.bytes[0] = cfg_i.erase_char;
          end
          B_EL: begin
            g.cnt      = 2'd1;
            g.bytes[0] = cfg_i.kill_char;
          end
          B_SB: n.phase = PH_SB;
          B_WILL, B_WONT, B_DO, B_DONT: begin
            n.verb  = verb_e'(2'(c - B_WILL));
            n.phase = PH_OPT;
          end
          B_IAC: begin
            g.cnt      = 2'd1;
            g.bytes[0] = B_IAC;
          end
          default: ;
        endcase
      end
      PH_OPT: begin
        n.phase = PH_DATA;
        neg_go  = 1'b1;
      end
      PH_SB: begin
        if (c == B_IAC) begin
          n.phase = PH_SBIAC;
        end
      end
      PH_SBIAC: begin
        n.phase = (c == B_SE) ? PH_DATA : PH_SB;
      end
      default: begin
        if (c == B_IAC) begin
          n.phase = PH_CMD;
        end else begin
          data_go = 1'b1;
        end
      end
    endcase

    if (data_go) begin
      if (word_i.discard_data) begin
        n.phase = PH_DATA;
      end else begin
        g.cnt      = 2'd1;
        g.bytes[0] = c;
        n.phase    = (!st_i.binary_out && c == B_CR) ? PH_CR : PH_DATA;
      end
    end

    if (neg_go) begin
      reply = (st_i.verb == VERB_WILL || st_i.verb == VERB_WONT) ? B_DONT : B_WONT;
      if (c == OPT_ECHO && (st_i.verb == VERB_DO || st_i.verb == VERB_DONT)) begin
        if (st_i.verb == VERB_DO) begin
          if (!st_i.login_echo) begin
            n.tty_flags = st_i.tty_flags | ECHO_MASK;
          end
          reply = B_WILL;
        end else begin
          n.tty_flags = st_i.tty_flags & ~ECHO_MASK;
          reply       = B_WONT;
        end
        n.login_echo = 1'b0;
        if (!st_i.echo_answered) begin
          n.echo_answered = 1'b1;
          silent          = 1'b1;
        end
      end else if (c == OPT_BINARY) begin
        case (st_i.verb)
          VERB_DO: begin
            enter       = 1'b1;
            n.binary_in = 1'b1;
            reply       = B_WILL;
          end
          VERB_WILL: begin
            enter        = 1'b1;
            n.binary_out = 1'b1;
            reply        = B_DO;
          end
          VERB_DONT: begin
            leave       = st_i.binary_in && !st_i.binary_out;
            n.binary_in = 1'b0;
            reply       = B_WONT;
          end
          default: begin
            leave        = st_i.binary_out && !st_i.binary_in;
            n.binary_out = 1'b0;
            reply        = B_DONT;
          end
        endcase
        if (enter && !st_i.binary_in && !st_i.binary_out) begin
          n.saved_flags = st_i.tty_flags & ~ECHO_MASK;
          n.tty_flags   = (st_i.tty_flags & ECHO_MASK) | RAW_MASK;
        end
        if (leave) begin
          n.tty_flags = (st_i.tty_flags & ECHO_MASK) | (st_i.saved_flags & ~RAW_MASK);
        end
      end
      if (!silent) begin
        g.cnt      = 2'd3;
        g.dests    = 3'b111;
        g.bytes[0] = B_IAC;
        g.bytes[1] = reply;
        g.bytes[2] = c;
      end
    end

    g.flags = n.tty_flags;
  end

  assign st_o  = n;
  assign grp_o = g;

endmodule

// ----- hdl/telnet_receive_negotiator.sv -----
// Top level of the telnet receive negotiator: state, config registers, result queue.
//
//  channel   direction  handshake                word
//  in        sink       in_valid_i / in_stall_o  in_word_i   (rx_byte, discard_data)
//  out       source     out_valid_o / out_stall_i out_word_o (dest, byte, flags, last)
//  config    APB slave  psel/penable/pready      pwdata/prdata, 4 word-spaced regs
//
// A byte is parsed in the cycle it is accepted; its result group is registered in the queue.
// Output runs one word per cycle while out_stall_i is low: a negotiation reply is 3 words, other results 1.
// A two-group result queue lets a new byte enter while results still wait.
// in_stall_o rises only when both queue slots hold undelivered groups.
// Reset clears parse state and queue at once; no clearing pass is needed.
module telnet_receive_negotiator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tnr_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tnr_pkg::out_word_t                 out_word_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tnr_pkg::ADDR_W-1:0]         paddr,
  input  logic [tnr_pkg::DATA_W-1:0]         pwdata,
  output logic [tnr_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tnr_pkg::*;

  cfg_t        cfg_q;
  logic [15:0] init_tty_q;
  st_t         st_q;
  st_t         st_d;
  grp_t        grp;
  grp_t        q_grp_q [2];
  logic [1:0]  q_vld_q;
  logic [1:0]  q_vld_d;
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  idx_q;
  grp_t        head;
  logic        in_acc;
  logic        out_acc;
  logic        push;
  logic        pop;
  logic        cfg_wr;
  reg_idx_e    reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_INTR:  prdata = DATA_W'(cfg_q.intr_char);
      REG_ERASE: prdata = DATA_W'(cfg_q.erase_char);
      REG_KILL:  prdata = DATA_W'(cfg_q.kill_char);
      REG_TTY:   prdata = DATA_W'(init_tty_q);
      default:   prdata = '0;
    endcase
  end

  tnr_decode u_decode (
    .st_i   (st_q),
    .word_i (in_word_i),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .grp_o  (grp)
  );

  assign in_stall_o  = q_vld_q[wr_ptr_q];
  assign in_acc      = in_valid_i && !in_stall_o;
  assign push        = in_acc && (grp.cnt != 2'd0);
  assign head        = q_grp_q[rd_ptr_q];
  assign out_valid_o = q_vld_q[rd_ptr_q];
  assign out_acc     = out_valid_o && !out_stall_i;
  assign pop         = out_acc && out_word_o.last;

  assign out_word_o.out_dest   = head.dests[idx_q];
  assign out_word_o.out_byte   = head.bytes[idx_q];
  assign out_word_o.mode_flags = head.flags;
  assign out_word_o.last       = (idx_q == head.cnt - 2'd1);

  always_comb begin
    q_vld_d = q_vld_q;
    if (push) begin
      q_vld_d[wr_ptr_q] = 1'b1;
    end
    if (pop) begin
      q_vld_d[rd_ptr_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.intr_char  <= INTR_RST;
      cfg_q.erase_char <= ERASE_RST;
      cfg_q.kill_char  <= KILL_RST;
      init_tty_q       <= TTY_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_INTR:  cfg_q.intr_char  <= pwdata[7:0];
        REG_ERASE: cfg_q.erase_char <= pwdata[7:0];
        REG_KILL:  cfg_q.kill_char  <= pwdata[7:0];
        REG_TTY:   init_tty_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase         <= PH_DATA;
      st_q.verb          <= VERB_WILL;
      st_q.echo_answered <= 1'b0;
      st_q.login_echo    <= 1'b1;
      st_q.binary_in     <= 1'b0;
      st_q.binary_out    <= 1'b0;
      st_q.tty_flags     <= TTY_RST;
      st_q.saved_flags   <= '0;
    end else if (cfg_wr && reg_sel == REG_TTY) begin
      st_q.tty_flags <= pwdata[15:0];
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      q_vld_q <= q_vld_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= '0;
      end else if (out_acc) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_grp_q[wr_ptr_q] <= grp;
    end
  end

endmodule

// ----- hdl/tnr_checker.sv -----
// Port-level checks of the telnet receive negotiator, bound to the top level.
`include "telnet_receive_negotiator_macros.svh"

module tnr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input tnr_pkg::in_word_t          in_word_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input tnr_pkg::out_word_t         out_word_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [tnr_pkg::ADDR_W-1:0] paddr,
  input logic [tnr_pkg::DATA_W-1:0] pwdata,
  input logic [tnr_pkg::DATA_W-1:0] prdata,
  input logic                       pready
);
  import tnr_pkg::*;

  `TNR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "stalled output word changed")
  `TNR_ASSERT(a_term_single, out_valid_o && !out_word_o.out_dest |-> out_word_o.last, "terminal word not alone in its run")
  `TNR_ASSERT(a_run_cont, out_valid_o && !out_stall_i && !out_word_o.last |=> out_valid_o && out_word_o.out_dest && (out_word_o.mode_flags == $past(out_word_o.mode_flags)), "reply run broken or flags changed inside it")
  `TNR_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "block not idle after reset")

endmodule

bind telnet_receive_negotiator tnr_checker u_tnr_checker (.*);
